// ----- design/kshash_pkg.sv -----
// Shared types and constants for the keyed SHA-1 range hash.
package kshash_pkg;

  localparam int KEY_BYTES    = 16;
  localparam int DIGEST_WORDS = 5;
  localparam int ADDR_W       = 5;

  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LEN  = 2'd2;
  localparam logic [1:0] REG_MODULUS  = 2'd3;

  localparam logic [31:0] H_INIT [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                         32'h10325476, 32'hC3D2E1F0};
  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  typedef enum logic [3:0] {
    ST_IDLE, ST_KEY, ST_DATA, ST_PADB, ST_PADZ, ST_PADL,
    ST_CSTART, ST_CWAIT, ST_FSTART, ST_FWAIT, ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic init;
  } rnd_ctl_t;

endpackage

// ----- design/keyed_sha1_range_hash.sv -----
// Top level: register port, byte sequencer, SHA-1 round unit and range fold.
// Each data word is first registered and then written into the block buffer,
// and the key is fed in at one byte per cycle, except while a block is
// compressed, ahead of the first data word of a message. Every full 64-byte
// block runs the shared SHA-1 round unit (start, 80 rounds, chaining add,
// handoff), during which no word is accepted. The final word adds 9 to 72
// padding bytes, one byte per cycle outside its one or two compressions,
// and then four passes of the bit-serial remainder unit produce the result.
module keyed_sha1_range_hash (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kshash_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [30:0]                   out_hash_value
);

  logic [63:0] key_low_r, key_high_r;
  logic [4:0]  key_length_r;
  logic [30:0] modulus_r;

  kshash_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [31:0] blk_r [16];
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bitlen_r, bitlen_nxt;
  logic        key_ins_r, key_ins_nxt;
  logic [4:0]  klen_r, klen_nxt;
  logic [3:0]  key_idx_r, key_idx_nxt;
  logic [2:0]  len_idx_r, len_idx_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic [31:0] fold_r, fold_nxt;
  logic [2:0]  fidx_r, fidx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [30:0] out_hash_r, out_hash_nxt;

  logic                 put_en;
  logic [7:0]           put_byte;
  kshash_pkg::state_t   after;
  kshash_pkg::rnd_ctl_t rctl;
  logic                 mod_start, rnd_done, mod_done;
  logic [511:0]         block;
  logic [31:0]          h [5];
  logic [30:0]          rem;
  logic [4:0]           key_eff;
  logic [63:0]          key_src;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r    <= '0;
      key_high_r   <= '0;
      key_length_r <= '0;
      modulus_r    <= 31'd1;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        kshash_pkg::REG_KEY_LOW:  key_low_r    <= pwdata;
        kshash_pkg::REG_KEY_HIGH: key_high_r   <= pwdata;
        kshash_pkg::REG_KEY_LEN:  key_length_r <= pwdata[4:0];
        kshash_pkg::REG_MODULUS:  modulus_r    <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      kshash_pkg::REG_KEY_LOW:  prdata = key_low_r;
      kshash_pkg::REG_KEY_HIGH: prdata = key_high_r;
      kshash_pkg::REG_KEY_LEN:  prdata = {59'd0, key_length_r};
      kshash_pkg::REG_MODULUS:  prdata = {33'd0, modulus_r};
      default:                  prdata = '0;
    endcase
  end

  assign key_eff = (key_length_r > 5'(kshash_pkg::KEY_BYTES)) ?
                   5'(kshash_pkg::KEY_BYTES) : key_length_r;
  assign key_src = key_idx_r[3] ? key_high_r : key_low_r;

  always_comb for (int i = 0; i < 16; i++) block[511 - 32*i -: 32] = blk_r[i];

  assign in_stall = (state_r != kshash_pkg::ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    fill_nxt      = fill_r;
    bitlen_nxt    = bitlen_r;
    key_ins_nxt   = key_ins_r;
    klen_nxt      = klen_r;
    key_idx_nxt   = key_idx_r;
    len_idx_nxt   = len_idx_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    fold_nxt      = fold_r;
    fidx_nxt      = fidx_r;
    out_valid_nxt = out_valid_r;
    out_hash_nxt  = out_hash_r;
    put_en        = 1'b0;
    put_byte      = '0;
    after         = kshash_pkg::ST_IDLE;
    rctl          = '0;
    mod_start     = 1'b0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      kshash_pkg::ST_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_data_byte;
          last_nxt = in_last_byte;
          if (!key_ins_r && key_eff != 5'd0) begin
            klen_nxt    = key_eff;
            key_idx_nxt = '0;
            state_nxt   = kshash_pkg::ST_KEY;
          end else begin
            state_nxt = kshash_pkg::ST_DATA;
          end
          key_ins_nxt = 1'b1;
        end
      end
      kshash_pkg::ST_KEY: begin
        put_en      = 1'b1;
        put_byte    = key_src[8*key_idx_r[2:0] +: 8];
        bitlen_nxt  = bitlen_r + 64'd8;
        key_idx_nxt = key_idx_r + 4'd1;
        after = ({1'b0, key_idx_r} + 5'd1 == klen_r) ? kshash_pkg::ST_DATA
                                                    : kshash_pkg::ST_KEY;
      end
      kshash_pkg::ST_DATA: begin
        put_en     = 1'b1;
        put_byte   = byte_r;
        bitlen_nxt = bitlen_r + 64'd8;
        after      = last_r ? kshash_pkg::ST_PADB : kshash_pkg::ST_IDLE;
      end
      kshash_pkg::ST_PADB: begin
        put_en   = 1'b1;
        put_byte = kshash_pkg::PAD_MARK;
        after    = kshash_pkg::ST_PADZ;
      end
      kshash_pkg::ST_PADZ: begin
        if (fill_r == kshash_pkg::LEN_START) begin
          len_idx_nxt = '0;
          state_nxt   = kshash_pkg::ST_PADL;
        end else begin
          put_en = 1'b1;
          after  = kshash_pkg::ST_PADZ;
        end
      end
      kshash_pkg::ST_PADL: begin
        put_en      = 1'b1;
        put_byte    = bitlen_r[8*(3'd7 - len_idx_r) +: 8];
        len_idx_nxt = len_idx_r + 3'd1;
        after = (len_idx_r == 3'd7) ? kshash_pkg::ST_FSTART : kshash_pkg::ST_PADL;
      end
      kshash_pkg::ST_CSTART: begin
        rctl.start = 1'b1;
        state_nxt  = kshash_pkg::ST_CWAIT;
      end
      kshash_pkg::ST_CWAIT: begin
        if (rnd_done) begin
          state_nxt = ret_r;
          if (ret_r == kshash_pkg::ST_FSTART) begin
            fold_nxt = h[0];
            fidx_nxt = 3'd1;
          end
        end
      end
      kshash_pkg::ST_FSTART: begin
        mod_start = 1'b1;
        state_nxt = kshash_pkg::ST_FWAIT;
      end
      kshash_pkg::ST_FWAIT: begin
        if (mod_done) begin
          fold_nxt = {1'b0, rem};
          fidx_nxt = fidx_r + 3'd1;
          state_nxt = (fidx_r == 3'(kshash_pkg::DIGEST_WORDS - 1)) ?
                      kshash_pkg::ST_EMIT : kshash_pkg::ST_FSTART;
        end
      end
      kshash_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = (modulus_r == 31'd0) ? 31'd0 : fold_r[30:0];
          rctl.init     = 1'b1;
          fill_nxt      = '0;
          bitlen_nxt    = '0;
          key_ins_nxt   = 1'b0;
          state_nxt     = kshash_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kshash_pkg::ST_IDLE;
    endcase

    if (put_en) begin
      if (fill_r == 6'd63) begin
        fill_nxt  = '0;
        ret_nxt   = after;
        state_nxt = kshash_pkg::ST_CSTART;
      end else begin
        fill_nxt  = fill_r + 6'd1;
        state_nxt = after;
      end
    end
  end

  // byte 0 of each word lands in the top lane
  always_ff @(posedge clk) begin
    if (put_en) blk_r[fill_r[5:2]][8*(2'd3 - fill_r[1:0]) +: 8] <= put_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kshash_pkg::ST_IDLE;
      ret_r       <= kshash_pkg::ST_IDLE;
      fill_r      <= '0;
      bitlen_r    <= '0;
      key_ins_r   <= 1'b0;
      klen_r      <= '0;
      key_idx_r   <= '0;
      len_idx_r   <= '0;
      fidx_r      <= '0;
      fold_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      fill_r      <= fill_nxt;
      bitlen_r    <= bitlen_nxt;
      key_ins_r   <= key_ins_nxt;
      klen_r      <= klen_nxt;
      key_idx_r   <= key_idx_nxt;
      len_idx_r   <= len_idx_nxt;
      fidx_r      <= fidx_nxt;
      fold_r      <= fold_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
    out_hash_r <= out_hash_nxt;
  end

  kshash_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (rctl),
    .block (block),
    .done  (rnd_done),
    .h     (h)
  );

  kshash_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .hi      (h[fidx_r]),
    .lo      (fold_r),
    .modulus (modulus_r),
    .done    (mod_done),
    .rem     (rem)
  );

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

// ----- design/kshash_round.sv -----
// SHA-1 compression: one round per cycle over a 16-word schedule window.
module kshash_round (
  input  logic                clk,
  input  logic                rst_n,
  input  kshash_pkg::rnd_ctl_t ctl,
  input  logic [511:0]        block,
  output logic                done,
  output logic [31:0]         h [5]
);

  logic [31:0] h_r [5];
  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [6:0]  rnd_r;
  logic        busy_r, add_r, done_r;
  logic [31:0] f, k, t, w_new;

  always_comb begin
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = kshash_pkg::K_0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = kshash_pkg::K_1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = kshash_pkg::K_2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = kshash_pkg::K_3;
    end
    t     = {a_r[26:0], a_r[31:27]} + f + e_r + k + w_r[0];
    w_new = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      add_r  <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= '0;
      for (int i = 0; i < 5; i++) h_r[i] <= kshash_pkg::H_INIT[i];
    end else begin
      done_r <= 1'b0;
      if (ctl.init) begin
        for (int i = 0; i < 5; i++) h_r[i] <= kshash_pkg::H_INIT[i];
      end else if (ctl.start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
        a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
        for (int i = 0; i < 16; i++) w_r[i] <= block[511 - 32*i -: 32];
      end else if (busy_r) begin
        a_r <= t;
        b_r <= a_r;
        c_r <= {b_r[1:0], b_r[31:2]};
        d_r <= c_r;
        e_r <= d_r;
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= w_new;
        rnd_r <= rnd_r + 7'd1;
        if (rnd_r == 7'd79) begin
          busy_r <= 1'b0;
          add_r  <= 1'b1;
        end
      end else if (add_r) begin
        // fold the working variables into the chaining words
        h_r[0] <= h_r[0] + a_r;
        h_r[1] <= h_r[1] + b_r;
        h_r[2] <= h_r[2] + c_r;
        h_r[3] <= h_r[3] + d_r;
        h_r[4] <= h_r[4] + e_r;
        add_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  always_comb for (int i = 0; i < 5; i++) h[i] = h_r[i];

endmodule

// ----- design/kshash_mod.sv -----
// Bit-serial restoring remainder of a 64-bit word by a 31-bit modulus.
module kshash_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] hi,
  input  logic [31:0] lo,
  input  logic [30:0] modulus,
  output logic        done,
  output logic [30:0] rem
);

  logic [63:0] num_r;
  logic [31:0] r_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [31:0] rs;

  always_comb begin
    rs = {r_r[30:0], num_r[63]};
    if (rs >= {1'b0, modulus}) rs = rs - {1'b0, modulus};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= {hi, lo};
        r_r    <= '0;
      end else if (busy_r) begin
        r_r   <= rs;
        num_r <= {num_r[62:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = r_r[30:0];

endmodule

// ----- design/kshash_checker.sv -----
// Port-level checks for the keyed SHA-1 range hash, bound to the top level.
module kshash_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        pready,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [30:0] out_hash_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_hash_value))
    else $error("stalled result word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input word taken without a busy cycle");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && pready)
    else $error("output valid after reset");

endmodule

bind keyed_sha1_range_hash kshash_checker u_kshash_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .pready         (pready),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hash_value (out_hash_value)
);

// ----- dv/tb_top.sv -----
// Testbench for keyed_sha1_range_hash: a SHA-1 predictor, a byte driver and a result monitor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES  = 600;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_word_t;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [kshash_pkg::ADDR_W-1:0] paddr;
  logic [63:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_stall, in_last_byte;
  logic [7:0]  in_data_byte;
  logic        out_valid, out_stall;
  logic [30:0] out_hash_value;

  keyed_sha1_range_hash u_top (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte), .out_valid(out_valid), .out_stall(out_stall),
    .out_hash_value(out_hash_value)
  );

  // Register copies and hash state of the predictor
  logic [63:0] key_lo, key_hi;
  logic [4:0]  key_len;
  logic [30:0] modulus;
  logic [31:0] chain [5];
  logic [7:0]  blk [64];
  int unsigned blk_fill;
  logic [63:0] bit_count;
  logic        key_done;

  byte_word_t  byte_q [$];
  logic [30:0] hash_q [$];
  int          idle_in_pct, idle_out_pct;
  int          errors, bytes_sent, hashes_seen, hold_cnt;
  logic        hold_done;
  int          quiet_cnt;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic sha_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = kshash_pkg::K_0;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = kshash_pkg::K_1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = kshash_pkg::K_2;
      end else begin
        f = b ^ c ^ d; k = kshash_pkg::K_3;
      end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  task automatic put_byte(input logic [7:0] v);
    blk[blk_fill] = v;
    blk_fill++;
    if (blk_fill == 64) begin
      sha_compress();
      blk_fill = 0;
    end
  endtask

  task automatic hash_restart();
    for (int i = 0; i < 5; i++) chain[i] = kshash_pkg::H_INIT[i];
    blk_fill  = 0;
    bit_count = '0;
    key_done  = 1'b0;
  endtask

  task automatic absorb(input logic [7:0] v);
    put_byte(v);
    bit_count += 64'd8;
  endtask

  // Feed one accepted word; queue the folded digest on the last word.
  task automatic predict_word(input logic [7:0] data, input logic last);
    int n;
    logic [63:0] src;
    logic [63:0] len;
    logic [63:0] num;
    logic [31:0] v;
    if (!key_done) begin
      n = (key_len > kshash_pkg::KEY_BYTES) ? kshash_pkg::KEY_BYTES : key_len;
      for (int i = 0; i < n; i++) begin
        src = (i < 8) ? key_lo : key_hi;
        absorb(src[8*(i%8) +: 8]);
      end
      key_done = 1'b1;
    end
    absorb(data);
    if (last) begin
      len = bit_count;
      put_byte(kshash_pkg::PAD_MARK);
      while (blk_fill != kshash_pkg::LEN_START) put_byte(8'h00);
      for (int i = 7; i >= 0; i--) put_byte(len[8*i +: 8]);
      v = chain[0];
      for (int i = 1; i < kshash_pkg::DIGEST_WORDS; i++) begin
        num = {chain[i], v};
        v = (modulus == 0) ? 32'd0 : 32'(num % {33'd0, modulus});
      end
      hash_q.push_back(v[30:0]);
      hash_restart();
    end
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      kshash_pkg::REG_KEY_LOW:  key_lo  = value;
      kshash_pkg::REG_KEY_HIGH: key_hi  = value;
      kshash_pkg::REG_KEY_LEN:  key_len = value[4:0];
      kshash_pkg::REG_MODULUS:  modulus = value[30:0];
      default: ;
    endcase
  endtask

  task automatic push_message(input int len);
    byte_word_t w;
    for (int i = 0; i < len; i++) begin
      w.data = 8'($urandom);
      w.last = (i == len - 1);
      byte_q.push_back(w);
    end
  endtask

  task automatic push_random_messages(input int total);
    int count, len, pick;
    count = 0;
    while (count < total) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)      len = $urandom_range(50, 70);
      else if (pick == 1) len = $urandom_range(110, 130);
      else                len = $urandom_range(1, 10);
      push_message(len);
      count += len;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (byte_q.size() != 0 || in_valid || hash_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: hold the word while stalled, otherwise advance or idle
  always @(posedge clk) begin
    byte_word_t w;
    logic       v;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_word(in_data_byte, in_last_byte);
        bytes_sent++;
      end
      if (!in_valid || !in_stall) begin
        v = 1'b0;
        if (byte_q.size() != 0 && $urandom_range(0, 99) >= idle_in_pct) begin
          w = byte_q.pop_front();
          v = 1'b1;
          in_data_byte <= w.data;
          in_last_byte <= w.last;
        end
        in_valid <= v;
      end
    end
  end

  // Monitor: compare each hash with the oldest expectation
  always @(posedge clk) begin
    logic [30:0] exp_hash;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        hashes_seen++;
        if (hash_q.size() == 0) begin
          $display("%0t: unexpected hash %h", $realtime, out_hash_value);
          errors++;
        end else begin
          exp_hash = hash_q.pop_front();
          if (exp_hash !== out_hash_value) begin
            $display("%0t: hash_value expected %h actual %h", $realtime, exp_hash,
                     out_hash_value);
            errors++;
          end
        end
      end
      // one long hold-off while the sender keeps offering words
      if (!hold_done && bytes_sent > 40 && hash_q.size() != 0) begin
        hold_cnt  <= 1500;
        hold_done <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
      end
      out_stall <= (hold_cnt > 1) || ($urandom_range(0, 99) < idle_out_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= WATCHDOG_LIMIT) begin
      $display("keyed_sha1_range_hash test failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; in_data_byte = '0; in_last_byte = 1'b0; out_stall = 1'b0;
    key_lo = '0; key_hi = '0; key_len = '0; modulus = 31'd1;
    errors = 0; bytes_sent = 0; hashes_seen = 0; hold_cnt = 0; hold_done = 1'b0;
    quiet_cnt = 0;
    idle_in_pct = 31; idle_out_pct = 51;
    hash_restart();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int seg = 0; seg < 7; seg++) begin
      if (seg == 2 || seg == 3) begin
        idle_in_pct = 51; idle_out_pct = 31;
      end else if (seg >= 4) begin
        idle_in_pct = 0; idle_out_pct = 0;
      end
      case (seg)
        0: ;  // reset values: no key, modulus one
        1: begin
          cfg_write(kshash_pkg::REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
          cfg_write(kshash_pkg::REG_KEY_HIGH, 64'h0000_0000_0000_0000);
          cfg_write(kshash_pkg::REG_KEY_LEN, 64'd16);
          cfg_write(kshash_pkg::REG_MODULUS, 64'h7FFF_FFFF);
        end
        2: begin
          // oversize key length clamps to full key; zero modulus yields zero
          cfg_write(kshash_pkg::REG_KEY_HIGH, {$urandom, $urandom});
          cfg_write(kshash_pkg::REG_KEY_LEN, 64'd31);
          cfg_write(kshash_pkg::REG_MODULUS, 64'd0);
        end
        3: begin
          cfg_write(kshash_pkg::REG_KEY_LOW, {$urandom, $urandom});
          cfg_write(kshash_pkg::REG_KEY_LEN, 64'd1);
          cfg_write(kshash_pkg::REG_MODULUS, 64'd2);
        end
        default: begin
          cfg_write(kshash_pkg::REG_KEY_LOW, {$urandom, $urandom});
          cfg_write(kshash_pkg::REG_KEY_HIGH, {$urandom, $urandom});
          cfg_write(kshash_pkg::REG_KEY_LEN, 64'($urandom_range(0, 31)));
          cfg_write(kshash_pkg::REG_MODULUS, 64'($urandom_range(1, 32'h7FFF_FFFF)));
        end
      endcase
      if (seg == 0) begin
        byte_q.push_back('{8'h00, 1'b1});
        byte_q.push_back('{8'hFF, 1'b1});
        byte_q.push_back('{8'hAA, 1'b0});
        byte_q.push_back('{8'h55, 1'b0});
        byte_q.push_back('{8'hFF, 1'b1});
        push_message(20);
      end
      push_random_messages(seg == 0 ? 100 : 120);
      wait_drained();
    end

    $display("Sent %0d data words in 7 register settings (key 0..31 bytes, modulus 0..2^31-1),",
             bytes_sent);
    $display("checked %0d hashes under sender and receiver idling and a long hold-off.",
             hashes_seen);
    if (errors == 0) begin
      $display("keyed_sha1_range_hash test passed");
    end else begin
      $display("keyed_sha1_range_hash test failed");
    end
    $finish;
  end

endmodule
